// ----- src/ntmc_pkg.sv -----
// Shared constants and types for the n-gram table membership check.
// Fixed field widths, command and status codes, register indexes, defaults.
// No dependencies.
`default_nettype none

package ntmc_pkg;

  localparam int SYM_W      = 16;
  localparam int NUM_SYMS   = 8;
  localparam int CMD_W      = 2;
  localparam int ROW_W      = 10;
  localparam int GRAM_W     = 4;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_GRAM    = 8;
  localparam int DEF_SYMBOL_BITS = 16;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_START = 2'd1;
  localparam cmd_t CMD_PLAIN = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_ANOMALOUS = 2'd1;
  localparam status_t ST_ALIEN     = 2'd2;

  localparam cfg_idx_t CFG_GRAM_LEN    = 1'd0;
  localparam cfg_idx_t CFG_ENTRY_COUNT = 1'd1;

endpackage

`default_nettype wire

// ----- src/ntmc_req_if.sv -----
// Request channel: valid/ready handshake carrying one load or query item.
// Depends on ntmc_pkg for the field widths and the command type.
`default_nettype none

interface ntmc_req_if;
  import ntmc_pkg::*;

  logic                  valid;
  logic                  ready;
  cmd_t                  command;
  logic [ROW_W-1:0]      row_index;
  logic [SYM_W-1:0]      sym0;
  logic [SYM_W-1:0]      sym1;
  logic [SYM_W-1:0]      sym2;
  logic [SYM_W-1:0]      sym3;
  logic [SYM_W-1:0]      sym4;
  logic [SYM_W-1:0]      sym5;
  logic [SYM_W-1:0]      sym6;
  logic [SYM_W-1:0]      sym7;
  logic [SYM_W-1:0]      lead_value;

  modport source (
    output valid, command, row_index, sym0, sym1, sym2, sym3, sym4, sym5, sym6, sym7,
           lead_value,
    input  ready
  );

  modport sink (
    input  valid, command, row_index, sym0, sym1, sym2, sym3, sym4, sym5, sym6, sym7,
           lead_value,
    output ready
  );

endinterface

`default_nettype wire

// ----- src/ntmc_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one status item.
// Depends on ntmc_pkg for the status type.
`default_nettype none

interface ntmc_rsp_if;
  import ntmc_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;

  modport source (
    output valid, status,
    input  ready
  );

  modport sink (
    input  valid, status,
    output ready
  );

endinterface

`default_nettype wire

// ----- src/ntmc_table.sv -----
// Pattern table: one row of MAX_GRAM symbols per word, one write port and
// one read port with registered read data. Depends on nothing else.
`default_nettype none

module ntmc_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_GRAM    = 8,
  parameter int SYMBOL_BITS = 16,
  localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [AW-1:0]                         waddr_i,
  input  wire logic [MAX_GRAM-1:0][SYMBOL_BITS-1:0]  wdata_i,
  input  wire logic [AW-1:0]                         raddr_i,
  output logic      [MAX_GRAM-1:0][SYMBOL_BITS-1:0]  rdata_o
);

  logic [MAX_GRAM-1:0][SYMBOL_BITS-1:0] mem [TABLE_DEPTH];
  logic [MAX_GRAM-1:0][SYMBOL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/ntmc_search.sv -----
// Item controller: takes items, drives table writes, runs the binary search
// one probe per cycle against the table read port, holds the result item.
// Depends on ntmc_pkg.
`default_nettype none

module ntmc_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_GRAM    = 8,
  parameter int SYMBOL_BITS = 16,
  localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [ntmc_pkg::GRAM_W-1:0]           gram_len_i,
  input  wire logic [ntmc_pkg::COUNT_W-1:0]          entry_count_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire ntmc_pkg::cmd_t                        cmd_i,
  input  wire logic                                  lead_zero_i,
  input  wire logic                                  row_ok_i,
  input  wire logic [MAX_GRAM-1:0][SYMBOL_BITS-1:0]  win_i,
  output logic                                       wr_en_o,
  output logic      [AW-1:0]                         rd_addr_o,
  input  wire logic [MAX_GRAM-1:0][SYMBOL_BITS-1:0]  rd_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output ntmc_pkg::status_t                          status_o
);
  import ntmc_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_PROBE = 2'b10
  } state_e;

  state_e                               state_q, state_d;
  logic                                 out_valid_q, out_valid_d;
  status_t                              status_q, status_d;
  logic [MAX_GRAM-1:0][SYMBOL_BITS-1:0] win_q;
  logic [CW-1:0]                        lo_q, lo_d, hx_q, hx_d;
  logic [AW-1:0]                        mid_q;

  logic [GRAM_W-1:0] g_eff;
  logic [CW-1:0]     cnt;
  logic              in_fire;
  logic              load_win;
  logic              cmp_lt, cmp_gt, decided;
  logic [CW-1:0]     lo_nxt, hx_nxt;
  status_t           miss_status;

  // Clamp the configuration to what the table holds.
  always_comb begin
    if (gram_len_i == '0) begin
      g_eff = GRAM_W'(1);
    end else if (gram_len_i > GRAM_W'(MAX_GRAM)) begin
      g_eff = GRAM_W'(MAX_GRAM);
    end else begin
      g_eff = gram_len_i;
    end
    if (EW'(entry_count_i) > EW'(TABLE_DEPTH)) begin
      cnt = CW'(TABLE_DEPTH);
    end else begin
      cnt = CW'(entry_count_i);
    end
  end

  assign miss_status = (g_eff == GRAM_W'(1)) ? ST_ALIEN : ST_ANOMALOUS;

  // Lexicographic compare of the window against the probed row.
  always_comb begin
    cmp_lt  = 1'b0;
    cmp_gt  = 1'b0;
    decided = 1'b0;
    for (int i = 0; i < MAX_GRAM; i++) begin
      if (!decided && (GRAM_W'(i) < g_eff)) begin
        if (win_q[i] < rd_data_i[i]) begin
          cmp_lt  = 1'b1;
          decided = 1'b1;
        end else if (win_q[i] > rd_data_i[i]) begin
          cmp_gt  = 1'b1;
          decided = 1'b1;
        end
      end
    end
  end

  always_comb begin
    lo_nxt = lo_q;
    hx_nxt = hx_q;
    if (cmp_lt) begin
      hx_nxt = CW'(mid_q);
    end
    if (cmp_gt) begin
      lo_nxt = CW'(mid_q) + CW'(1);
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_en_o    = in_fire && (cmd_i == CMD_LOAD) && row_ok_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    lo_d        = lo_q;
    hx_d        = hx_q;
    load_win    = 1'b0;
    rd_addr_o   = AW'((cnt - CW'(1)) >> 1);
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            CMD_START, CMD_PLAIN: begin
              if ((cmd_i == CMD_PLAIN) && lead_zero_i) begin
                out_valid_d = 1'b1;
                status_d    = ST_OK;
              end else if (cnt == '0) begin
                out_valid_d = 1'b1;
                status_d    = ST_ANOMALOUS;
              end else begin
                // first probe goes out with the accept
                load_win = 1'b1;
                lo_d     = '0;
                hx_d     = cnt;
                state_d  = S_PROBE;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              status_d    = ST_OK;
            end
          endcase
        end
      end
      S_PROBE: begin
        lo_d      = lo_nxt;
        hx_d      = hx_nxt;
        rd_addr_o = AW'(lo_nxt + ((hx_nxt - CW'(1) - lo_nxt) >> 1));
        if (!cmp_lt && !cmp_gt) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          state_d     = S_IDLE;
        end else if (lo_nxt >= hx_nxt) begin
          out_valid_d = 1'b1;
          status_d    = miss_status;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    lo_q     <= lo_d;
    hx_q     <= hx_d;
    mid_q    <= rd_addr_o;
    if (load_win) begin
      win_q <= win_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ----- src/ngram_table_membership_check.sv -----
//  channel   | direction | handshake   | payload
//  req_i     | in        | valid/ready | command, row_index, sym0..sym7, lead_value
//  rsp_o     | out       | valid/ready | status
//  cfg_*_i   | in        | write only  | cfg_idx_i, cfg_data_i
//
// A load, a reserved command, a bypassed plain query or a query on an empty
// table gives its result in the cycle after the accept. A search makes one
// table probe per cycle through the single read port, at most
// ceil(log2(entries+1)) probes. One item is in work at a time; the next is
// taken once the result register is free or being drained. Reset clears the
// control state and registers; the table holds rows only from loads.
// Depends on ntmc_pkg, ntmc_req_if, ntmc_rsp_if, ntmc_table, ntmc_search.
`default_nettype none

module ngram_table_membership_check #(
  parameter int TABLE_DEPTH = ntmc_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_GRAM    = ntmc_pkg::DEF_MAX_GRAM,
  parameter int SYMBOL_BITS = ntmc_pkg::DEF_SYMBOL_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ntmc_req_if.sink                           req_i,
  ntmc_rsp_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire ntmc_pkg::cfg_idx_t            cfg_idx_i,
  input  wire logic [ntmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ntmc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [GRAM_W-1:0]                    gram_len_q;
  logic [COUNT_W-1:0]                   entry_count_q;
  logic [NUM_SYMS-1:0][SYM_W-1:0]       sym_all;
  logic [MAX_GRAM-1:0][SYMBOL_BITS-1:0] row;
  logic                                 row_ok;
  logic                                 wr_en;
  logic [AW-1:0]                        rd_addr;
  logic [MAX_GRAM-1:0][SYMBOL_BITS-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gram_len_q    <= GRAM_W'(1);
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAM_LEN:    gram_len_q    <= cfg_data_i[GRAM_W-1:0];
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign sym_all = {req_i.sym7, req_i.sym6, req_i.sym5, req_i.sym4,
                    req_i.sym3, req_i.sym2, req_i.sym1, req_i.sym0};

  // Keep the low SYMBOL_BITS of each symbol.
  always_comb begin
    for (int i = 0; i < MAX_GRAM; i++) begin
      row[i] = SYMBOL_BITS'(sym_all[i]);
    end
  end

  assign row_ok = (32'(req_i.row_index) < 32'(TABLE_DEPTH));

  ntmc_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_GRAM    (MAX_GRAM),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(req_i.row_index)),
    .wdata_i (row),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ntmc_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_GRAM    (MAX_GRAM),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gram_len_i    (gram_len_q),
    .entry_count_i (entry_count_q),
    .in_valid_i    (req_i.valid),
    .in_ready_o    (req_i.ready),
    .cmd_i         (req_i.command),
    .lead_zero_i   (req_i.lead_value == '0),
    .row_ok_i      (row_ok),
    .win_i         (row),
    .wr_en_o       (wr_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status)
  );

endmodule

`default_nettype wire

// ----- tb/sv/ngram_table_membership_check_test.sv -----
// Testbench for ngram_table_membership_check: drives loads and queries through the
// request channel and checks every status against a shadow table and search of its own.
// Depends on ntmc_pkg, ntmc_req_if, ntmc_rsp_if and the block itself.

module ngram_table_membership_check_test;
  import ntmc_pkg::*;

  localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
  localparam int MAX_GRAM     = DEF_MAX_GRAM;
  localparam int SYMBOL_BITS  = DEF_SYMBOL_BITS;
  localparam int SYM_MAX      = (1 << SYM_W) - 1;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 450;

  localparam cmd_t CMD_RESERVED = 2'd3;

  typedef logic [NUM_SYMS-1:0][SYM_W-1:0] window_t;

  typedef struct packed {
    cmd_t             command;
    logic [ROW_W-1:0] row_index;
    window_t          syms;
    logic [SYM_W-1:0] lead_value;
  } ngram_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] item_no;
  } status_exp_t;

  typedef enum int {WIN_HIT, WIN_NEAR, WIN_RANDOM} win_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_t              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ntmc_req_if req_if ();
  ntmc_rsp_if rsp_if ();

  ngram_table_membership_check #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_GRAM    (MAX_GRAM),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow of the block: table rows and both registers
  window_t           shadow_rows [TABLE_DEPTH];
  logic [GRAM_W-1:0]  cur_gram_len    = 4'd1;
  logic [COUNT_W-1:0] cur_entry_count = '0;

  status_exp_t pending_status [$];

  // Rows on the leftmost and rightmost probe paths of a full-depth search
  int edge_rows [$];

  bit src_gaps_on   = 1'b1;
  bit sink_stalls_on = 1'b1;
  int hold_off_left = 0;
  int errors        = 0;
  int n_items       = 0;
  int n_loads       = 0;
  int n_queries     = 0;
  int n_ok          = 0;
  int n_anomalous   = 0;
  int n_alien       = 0;
  int cycle_count   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_gap(input bit enabled);
    int roll;
    roll = $urandom_range(99);
    if (!enabled || roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [SYM_W-1:0] rand_symbol();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(SYM_W-1){1'b0}}};
      3: return SYM_W'($urandom_range(3));
      default: return SYM_W'($urandom);
    endcase
  endfunction

  function automatic int eff_gram();
    if (cur_gram_len == '0) return 1;
    if (int'(cur_gram_len) > MAX_GRAM) return MAX_GRAM;
    return int'(cur_gram_len);
  endfunction

  function automatic int eff_span();
    if (int'(cur_entry_count) > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(cur_entry_count);
  endfunction

  // Binary search over the shadow rows, same probe order as the block
  function automatic status_t search_window(input window_t win);
    int g, lo, hi, mid, order, i;
    g = eff_gram();
    if (eff_span() == 0) return ST_ANOMALOUS;
    lo = 0;
    hi = eff_span() - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      order = 0;
      for (i = 0; i < g && order == 0; i++) begin
        if (win[i] < shadow_rows[mid][i]) order = -1;
        else if (win[i] > shadow_rows[mid][i]) order = 1;
      end
      if (order == 0) return ST_OK;
      if (order < 0) hi = mid - 1;
      else lo = mid + 1;
    end
    return (g == 1) ? ST_ALIEN : ST_ANOMALOUS;
  endfunction

  function automatic status_t apply_item(input ngram_item_t item);
    case (item.command)
      CMD_LOAD: begin
        shadow_rows[item.row_index] = item.syms;
        return ST_OK;
      end
      CMD_START: return search_window(item.syms);
      CMD_PLAIN: return (item.lead_value == '0) ? ST_OK : search_window(item.syms);
      default: return ST_OK;
    endcase
  endfunction

  function automatic ngram_item_t make_item(input cmd_t command,
                                            input logic [ROW_W-1:0] row_index,
                                            input window_t syms,
                                            input logic [SYM_W-1:0] lead_value);
    ngram_item_t item;
    item.command    = command;
    item.row_index  = row_index;
    item.syms       = syms;
    item.lead_value = lead_value;
    return item;
  endfunction

  // Next row in ascending order: bump one symbol, keep the prefix, randomise the tail
  function automatic window_t next_sorted_row(input window_t prev);
    window_t row;
    int pos, step, i;
    row  = prev;
    pos  = $urandom_range(NUM_SYMS - 1);
    step = $urandom_range(40, 1);
    while (pos >= 0 && int'(prev[pos]) > SYM_MAX - step) pos--;
    if (pos < 0) return prev;
    row[pos] = prev[pos] + SYM_W'(step);
    for (i = pos + 1; i < NUM_SYMS; i++) row[i] = rand_symbol();
    return row;
  endfunction

  function automatic window_t query_window(input win_kind_e kind);
    window_t win, src_row;
    int g, q, i;
    g = eff_gram();
    for (i = 0; i < NUM_SYMS; i++) win[i] = rand_symbol();
    if (kind != WIN_RANDOM && eff_span() > 0) begin
      src_row = shadow_rows[$urandom_range(eff_span() - 1)];
      for (i = 0; i < g; i++) win[i] = src_row[i];
      if (kind == WIN_NEAR) begin
        q = $urandom_range(g - 1);
        win[q] = (win[q] == '1) ? win[q] - 1'b1 : win[q] + 1'b1;
      end
    end
    return win;
  endfunction

  // Call at a rising edge; returns at the edge where the item is taken
  task automatic offer_item(input ngram_item_t item);
    int gap;
    status_exp_t rec;
    gap = pick_gap(src_gaps_on);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= item.command;
    req_if.row_index  <= item.row_index;
    req_if.sym0       <= item.syms[0];
    req_if.sym1       <= item.syms[1];
    req_if.sym2       <= item.syms[2];
    req_if.sym3       <= item.syms[3];
    req_if.sym4       <= item.syms[4];
    req_if.sym5       <= item.syms[5];
    req_if.sym6       <= item.syms[6];
    req_if.sym7       <= item.syms[7];
    req_if.lead_value <= item.lead_value;
    do @(posedge clk_i); while (!req_if.ready);
    rec.status  = apply_item(item);
    rec.item_no = n_items;
    pending_status.push_back(rec);
    n_items++;
    if (item.command == CMD_LOAD) n_loads++;
    else if (item.command != CMD_RESERVED) n_queries++;
  endtask

  task automatic send_query(input cmd_t command, input win_kind_e kind,
                            input logic [SYM_W-1:0] lead);
    offer_item(make_item(command, ROW_W'($urandom), query_window(kind), lead));
  endtask

  task automatic load_sorted_rows(input int base_row, input int count, input window_t start);
    window_t row;
    int r;
    row = start;
    for (r = base_row; r < base_row + count; r++) begin
      offer_item(make_item(CMD_LOAD, ROW_W'(r), row, SYM_W'($urandom)));
      row = next_sorted_row(row);
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GRAM_LEN) cur_gram_len = value[GRAM_W-1:0];
    else cur_entry_count = value[COUNT_W-1:0];
  endtask

  function automatic cmd_t rand_query_cmd();
    return $urandom_range(1) ? CMD_START : CMD_PLAIN;
  endfunction

  function automatic logic [SYM_W-1:0] rand_lead();
    return SYM_W'($urandom_range(SYM_MAX, 1));
  endfunction

  // Hit on an edge row, or a window below or above every loaded row, so the
  // search only ever probes rows on the leftmost and rightmost edge paths
  task automatic send_edge_query();
    window_t win;
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) win = '0;
    else if (roll == 1) win = '1;
    else win = shadow_rows[edge_rows[$urandom_range(edge_rows.size() - 1)]];
    offer_item(make_item(rand_query_cmd(), ROW_W'($urandom), win, rand_lead()));
  endtask

  task automatic test_empty_table();
    send_query(CMD_START, WIN_RANDOM, rand_lead());
    offer_item(make_item(CMD_START, '0, '0, '0));
    offer_item(make_item(CMD_START, '1, '1, '1));
    send_query(CMD_PLAIN, WIN_RANDOM, '0);
    send_query(CMD_PLAIN, WIN_RANDOM, '1);
    offer_item(make_item(CMD_RESERVED, '1, '1, '1));
  endtask

  task automatic test_small_table();
    window_t row1;
    row1 = next_sorted_row('0);
    offer_item(make_item(CMD_LOAD, ROW_W'(0), '0, '0));
    offer_item(make_item(CMD_LOAD, ROW_W'(1), row1, '1));
    offer_item(make_item(CMD_LOAD, ROW_W'(2), next_sorted_row(row1), rand_lead()));
    offer_item(make_item(CMD_LOAD, ROW_W'(3), '1, '0));
    write_reg(CFG_GRAM_LEN, 11'd1);
    write_reg(CFG_ENTRY_COUNT, 11'd4);
    send_query(CMD_START, WIN_HIT, rand_lead());
    send_query(CMD_START, WIN_NEAR, rand_lead());
    send_query(CMD_PLAIN, WIN_HIT, rand_lead());
    send_query(CMD_PLAIN, WIN_NEAR, '0);
    // zero length counts as one symbol
    write_reg(CFG_GRAM_LEN, 11'd0);
    send_query(CMD_START, WIN_NEAR, rand_lead());
    write_reg(CFG_GRAM_LEN, 11'd8);
    send_query(CMD_START, WIN_NEAR, rand_lead());
    send_query(CMD_PLAIN, WIN_NEAR, rand_lead());
    offer_item(make_item(CMD_START, '0, '1, '1));
    offer_item(make_item(CMD_PLAIN, '1, '0, '1));
    // oversized length saturates; high data bits fall outside the register
    write_reg(CFG_GRAM_LEN, 11'd15);
    send_query(CMD_START, WIN_HIT, rand_lead());
    send_query(CMD_START, WIN_NEAR, rand_lead());
    write_reg(CFG_GRAM_LEN, 11'h7F3);
    send_query(CMD_START, WIN_HIT, rand_lead());
    write_reg(CFG_ENTRY_COUNT, 11'd1);
    send_query(CMD_START, WIN_NEAR, rand_lead());
  endtask

  // Full-depth search with only the edge paths loaded, in ascending order
  task automatic test_full_table();
    window_t row;
    int lo, hi, mid, i;
    edge_rows.delete();
    lo = 0;
    hi = TABLE_DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      edge_rows.push_back(mid);
      hi = mid - 1;
    end
    lo = (TABLE_DEPTH - 1) / 2 + 1;
    hi = TABLE_DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      edge_rows.push_back(mid);
      lo = mid + 1;
    end
    edge_rows.sort();
    // non-zero first symbol keeps the all-zero window below every row
    row = '0;
    row[0] = SYM_W'(100);
    foreach (edge_rows[k]) begin
      offer_item(make_item(CMD_LOAD, ROW_W'(edge_rows[k]), row, SYM_W'($urandom)));
      row = next_sorted_row(row);
    end
    write_reg(CFG_GRAM_LEN, 11'd8);
    write_reg(CFG_ENTRY_COUNT, 11'd1024);
    offer_item(make_item(CMD_START, '0, '0, rand_lead()));
    offer_item(make_item(CMD_PLAIN, '0, '1, rand_lead()));
    for (i = 0; i < 16; i++) send_edge_query();
    send_query(CMD_PLAIN, WIN_RANDOM, '0);
    // count above the depth saturates
    write_reg(CFG_ENTRY_COUNT, 11'd2047);
    write_reg(CFG_GRAM_LEN, 11'd1);
    for (i = 0; i < 10; i++) send_edge_query();
    write_reg(CFG_GRAM_LEN, 11'd3);
    write_reg(CFG_ENTRY_COUNT, 11'd1024);
    for (i = 0; i < 10; i++) send_edge_query();
    // back to a short span of written rows
    write_reg(CFG_ENTRY_COUNT, 11'd4);
  endtask

  task automatic test_backpressure();
    drain_results();
    src_gaps_on   = 1'b0;
    hold_off_left = 80;
    repeat (12) send_query(rand_query_cmd(), WIN_HIT, rand_lead());
    // pause until everything is back
    drain_results();
    src_gaps_on = 1'b1;
  endtask

  task automatic random_phase();
    int roll, span, r;
    logic [CFG_DATA_W-1:0] gram;
    window_t content;
    src_gaps_on    = ($urandom_range(3) != 0);
    sink_stalls_on = ($urandom_range(3) != 0);
    roll = $urandom_range(9);
    if (roll == 0) gram = '0;
    else if (roll == 1) gram = CFG_DATA_W'($urandom_range(15, 9));
    else if (roll == 2) gram = CFG_DATA_W'($urandom);
    else gram = CFG_DATA_W'($urandom_range(MAX_GRAM, 1));
    write_reg(CFG_GRAM_LEN, gram);
    roll = $urandom_range(19);
    if (roll == 0) span = 0;
    else span = $urandom_range(32, 1);
    if (span > 0) load_sorted_rows(0, span, query_window(WIN_RANDOM));
    write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(span));
    repeat ($urandom_range(25, 10)) begin
      roll = $urandom_range(99);
      if (roll < 40) send_query(rand_query_cmd(), WIN_HIT, rand_lead());
      else if (roll < 60) send_query(rand_query_cmd(), WIN_NEAR, rand_lead());
      else if (roll < 70) send_query(rand_query_cmd(), WIN_RANDOM, rand_lead());
      else if (roll < 78) send_query(CMD_PLAIN, win_kind_e'($urandom_range(2)), '0);
      else if (roll < 93) begin
        // duplicate of the row below keeps the order, random content breaks it
        r = $urandom_range((eff_span() > 1 ? eff_span() : 2) - 1);
        content = (r > 0 && $urandom_range(1)) ? shadow_rows[r-1] : query_window(WIN_RANDOM);
        offer_item(make_item(CMD_LOAD, ROW_W'(r), content, SYM_W'($urandom)));
      end else begin
        offer_item(make_item(CMD_RESERVED, ROW_W'($urandom), query_window(WIN_RANDOM),
                             SYM_W'($urandom)));
      end
    end
  endtask

  task automatic test_random_traffic();
    int target;
    target = n_items + RANDOM_ITEMS;
    while (n_items < target) random_phase();
  endtask

  // Result side: random stalls, long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = pick_gap(sink_stalls_on);
      end
    end
  end

  always @(posedge clk_i) begin
    status_exp_t head;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: status %0d arrived with no item outstanding", $time, rsp_if.status);
        errors++;
      end else begin
        head = pending_status.pop_front();
        if (rsp_if.status !== head.status) begin
          $display("%0t: item %0d status mismatch: expected %0d, actual %0d",
                   $time, head.item_no, head.status, rsp_if.status);
          errors++;
        end else if (head.status == ST_OK) n_ok++;
        else if (head.status == ST_ANOMALOUS) n_anomalous++;
        else n_alien++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run stopped after %0d cycles, %0d results outstanding",
             $time, cycle_count, pending_status.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main_seq
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_GRAM_LEN;
    cfg_data_i        <= '0;
    req_if.valid      <= 1'b0;
    req_if.command    <= CMD_LOAD;
    req_if.row_index  <= '0;
    req_if.sym0       <= '0;
    req_if.sym1       <= '0;
    req_if.sym2       <= '0;
    req_if.sym3       <= '0;
    req_if.sym4       <= '0;
    req_if.sym5       <= '0;
    req_if.sym6       <= '0;
    req_if.sym7       <= '0;
    req_if.lead_value <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_small_table();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d items: %0d row loads, %0d queries, the rest reserved commands.",
             n_items, n_loads, n_queries);
    $display("Statuses matched: %0d ok, %0d anomalous, %0d alien; %0d mismatches.",
             n_ok, n_anomalous, n_alien, errors);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
